FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skipped while reset is held.
`define SWM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("swm check failed");

// Check a property on every clock edge, reset cycles included.
`define SWM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("swm reset check failed");

`endif

FILE: rtl/swm_pkg.sv
package swm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int WINDOW_DEFAULT = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // What a ranking cell shows its neighbors.
  typedef struct packed {
    logic    present;  // cell exists at this position
    sample_t value;    // ranked value held by the cell
    logic    lt_old;   // value is below the sample leaving the window
    logic    lt_new;   // value is below the sample entering the window
  } link_t;

endpackage

FILE: rtl/swm_cell.sv
module swm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  swm_pkg::sample_t new_sample,
  input  swm_pkg::sample_t old_sample,
  input  logic            old_lt_new,
  input  swm_pkg::link_t  lower,
  input  swm_pkg::link_t  upper,
  input  swm_pkg::sample_t tap_in,
  output swm_pkg::sample_t tap_out,
  output swm_pkg::link_t  self_link,
  output swm_pkg::sample_t rank_nxt
);

  swm_pkg::sample_t tap_r;
  swm_pkg::sample_t rank_r;
  logic             lt_old;
  logic             lt_new;

  assign lt_old = rank_r < old_sample;
  assign lt_new = rank_r < new_sample;

  assign self_link.present = 1'b1;
  assign self_link.value   = rank_r;
  assign self_link.lt_old  = lt_old;
  assign self_link.lt_new  = lt_new;
  assign tap_out           = tap_r;

  // Drop the leaving value and open a slot for the entering one.
  always_comb begin
    rank_nxt = rank_r;
    if (old_lt_new) begin
      if (lt_old) begin
        rank_nxt = rank_r;
      end else if (upper.present && upper.lt_new) begin
        rank_nxt = upper.value;
      end else if (lt_new) begin
        rank_nxt = new_sample;
      end
    end else begin
      if (lt_new) begin
        rank_nxt = rank_r;
      end else if (!lower.present || lower.lt_new) begin
        rank_nxt = new_sample;
      end else if (lower.lt_old) begin
        rank_nxt = lower.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r  <= '0;
      rank_r <= '0;
    end else if (shift_en) begin
      tap_r  <= tap_in;
      rank_r <= rank_nxt;
    end
  end

endmodule

FILE: rtl/sliding_window_median.sv
// The median of a sample is registered and is on out_median_value after its transfer cycle.
// Throughput: one sample per cycle unless stalled; each cell updates in its transfer cycle.
// A result waiting on out_ready stalls the input only if it is not taken that cycle.
// Reset (rst_n low, synchronous): window and ranked row cleared to zeros,
// result register empty.
module sliding_window_median #(
  parameter int WINDOW = swm_pkg::WINDOW_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  swm_pkg::sample_t in_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output swm_pkg::sample_t out_median_value
);

  // Rank of the reported element: upper median for an even window.
  localparam int MID = WINDOW / 2;

  // Each cell holds one tap of the arrival-order delay line and one entry of
  // the window kept in ascending order. The last tap is the oldest sample,
  // the one that leaves the window on the next transfer.
  swm_pkg::sample_t tap_out  [WINDOW];
  swm_pkg::sample_t rank_nxt [WINDOW];
  swm_pkg::link_t   links    [WINDOW];

  swm_pkg::sample_t old_sample;
  logic             old_lt_new;
  logic             in_fire;
  logic             out_valid_r;
  swm_pkg::sample_t median_r;

  assign old_sample = tap_out[WINDOW-1];
  assign old_lt_new = old_sample < in_sample;

  // Accept while the result register is empty or being emptied this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      swm_pkg::link_t   lower_link;
      swm_pkg::link_t   upper_link;
      swm_pkg::sample_t tap_in;

      // Cells at the ends see an absent neighbor.
      if (gi == 0) begin : g_first
        assign lower_link = '0;
        assign tap_in     = in_sample;
      end else begin : g_mid_lo
        assign lower_link = links[gi-1];
        assign tap_in     = tap_out[gi-1];
      end

      if (gi == WINDOW - 1) begin : g_last
        assign upper_link = '0;
      end else begin : g_mid_hi
        assign upper_link = links[gi+1];
      end

      swm_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (in_fire),
        .new_sample (in_sample),
        .old_sample (old_sample),
        .old_lt_new (old_lt_new),
        .lower      (lower_link),
        .upper      (upper_link),
        .tap_in     (tap_in),
        .tap_out    (tap_out[gi]),
        .self_link  (links[gi]),
        .rank_nxt   (rank_nxt[gi])
      );
    end
  endgenerate

  // Capture the middle cell's new value as the result of this transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      median_r <= rank_nxt[MID];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = median_r;

endmodule

FILE: rtl/swm_checker.sv
`include "assert_macros.svh"

module swm_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input swm_pkg::sample_t out_median_value
);

  // Hold a stalled result.
  `SWM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_median_value))
  // Every input transfer yields a result on the next cycle.
  `SWM_ASSERT(a_result_follows, in_valid && in_ready |=> out_valid)
  // Never take a sample while a result is stuck.
  `SWM_ASSERT(a_no_overrun, out_valid && !out_ready |-> !in_ready)
  // No result appears without a sample behind it.
  `SWM_ASSERT(a_no_invent, !(in_valid && in_ready) && out_valid && out_ready |=> !out_valid)
  // Reset empties the result register.
  `SWM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_median_value (out_median_value)
);
